// ===== design/srrr_pkg.sv =====
// Shared types and constants for the selective-repeat reorder receiver.
// No dependencies; used by the queue, the engine and the top level.
`timescale 1ns / 1ps

package srrr_pkg;

    localparam int WIN_DEPTH   = 16;
    localparam int SLOT_W      = (WIN_DEPTH > 1) ? $clog2(WIN_DEPTH) : 1;
    localparam int CNT_W       = $clog2(WIN_DEPTH + 1);
    localparam int SEQ_W       = 16;
    localparam int PAY_W       = 32;
    localparam int LIMIT_W     = 5;
    localparam int STAT_W      = 3;

    localparam logic [SEQ_W-1:0]   HALF_SEQ    = 16'h8000;
    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 5'd16;

    localparam logic KIND_DATA = 1'b0;
    localparam logic KIND_ACK  = 1'b1;

    localparam logic [STAT_W-1:0] STAT_IN_ORDER  = 3'd0;
    localparam logic [STAT_W-1:0] STAT_BUFFERED  = 3'd1;
    localparam logic [STAT_W-1:0] STAT_DUPLICATE = 3'd2;
    localparam logic [STAT_W-1:0] STAT_STALE     = 3'd3;
    localparam logic [STAT_W-1:0] STAT_BEYOND    = 3'd4;

    typedef struct packed {
        logic [SEQ_W-1:0] seq;
        logic [PAY_W-1:0] payload;
    } pkt_t;

    typedef struct packed {
        logic              kind;
        logic [SEQ_W-1:0]  seq;
        logic [PAY_W-1:0]  payload;
        logic [STAT_W-1:0] status;
        logic              last;
    } out_item_t;

endpackage

// ===== design/srrr_in_queue.sv =====
// Two-entry input queue between the packet port and the engine.
// Depends on srrr_pkg for the packet type.
`timescale 1ns / 1ps

module srrr_in_queue
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push_valid,
    output logic          push_ready,
    input  srrr_pkg::pkt_t push_item,
    output logic          head_valid,
    output srrr_pkg::pkt_t head_item,
    input  logic          pop
);

    srrr_pkg::pkt_t entry_reg [2];
    logic           wr_ptr_reg;
    logic           wr_ptr_next;
    logic           rd_ptr_reg;
    logic           rd_ptr_next;
    logic [1:0]     count_reg;
    logic [1:0]     count_next;
    logic           push;
    logic           do_pop;

    assign push_ready = (count_reg != 2'd2);
    assign push       = push_valid && push_ready;
    assign head_valid = (count_reg != 2'd0);
    assign head_item  = entry_reg[rd_ptr_reg];
    assign do_pop     = pop && head_valid;

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !do_pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (do_pop && !push)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

// ===== design/srrr_engine.sv =====
// Back end: classifies the queued packet, keeps the reorder store and
// sequences deliveries and acknowledgements into the output register.
// Depends on srrr_pkg.
`timescale 1ns / 1ps

module srrr_engine
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         q_valid,
    input  srrr_pkg::pkt_t               q_item,
    output logic                         q_pop,
    input  logic [srrr_pkg::LIMIT_W-1:0] window_limit,
    output logic                         out_valid,
    input  logic                         out_ready,
    output srrr_pkg::out_item_t          out_item
);

    localparam logic ST_IDLE  = 1'b0;
    localparam logic ST_DRAIN = 1'b1;

    logic                          state_reg;
    logic                          state_next;
    logic [srrr_pkg::SEQ_W-1:0]    expected_reg;
    logic [srrr_pkg::SEQ_W-1:0]    expected_next;
    logic [srrr_pkg::SLOT_W-1:0]   head_reg;
    logic [srrr_pkg::SLOT_W-1:0]   head_next;
    logic [srrr_pkg::SLOT_W-1:0]   head_inc;
    logic [srrr_pkg::WIN_DEPTH-1:0] slot_valid_reg;
    logic [srrr_pkg::WIN_DEPTH-1:0] slot_valid_next;
    logic [srrr_pkg::PAY_W-1:0]    slot_mem [srrr_pkg::WIN_DEPTH];
    logic [srrr_pkg::PAY_W-1:0]    rd_data_reg;

    logic                          out_valid_reg;
    logic                          out_valid_next;
    srrr_pkg::out_item_t           out_item_reg;
    srrr_pkg::out_item_t           out_item_next;

    logic                          can_emit;
    logic                          emit;
    logic [srrr_pkg::SEQ_W-1:0]    seq_off;
    logic                          in_order;
    logic                          in_window;
    logic [srrr_pkg::CNT_W:0]      slot_sum;
    logic [srrr_pkg::SLOT_W-1:0]   wr_slot;
    logic                          wr_en;
    logic                          drain_hit;
    logic [srrr_pkg::STAT_W-1:0]   cls_status;

    assign can_emit = !out_valid_reg || out_ready;
    assign seq_off  = q_item.seq - expected_reg;
    assign in_order = (seq_off == '0);
    assign in_window = !in_order
                       && (seq_off <= srrr_pkg::SEQ_W'(window_limit))
                       && (seq_off <= srrr_pkg::SEQ_W'(srrr_pkg::WIN_DEPTH));

    // Offset is at most the window depth, so one subtract wraps the slot.
    assign slot_sum = (srrr_pkg::CNT_W+1)'(head_reg)
                      + (srrr_pkg::CNT_W+1)'(seq_off[srrr_pkg::CNT_W-1:0]);
    assign wr_slot  = (slot_sum >= (srrr_pkg::CNT_W+1)'(srrr_pkg::WIN_DEPTH))
                      ? srrr_pkg::SLOT_W'(slot_sum
                                          - (srrr_pkg::CNT_W+1)'(srrr_pkg::WIN_DEPTH))
                      : srrr_pkg::SLOT_W'(slot_sum);

    assign head_inc = (head_reg == srrr_pkg::SLOT_W'(srrr_pkg::WIN_DEPTH - 1))
                      ? '0 : head_reg + srrr_pkg::SLOT_W'(1);

    assign drain_hit = slot_valid_reg[head_reg];

    always_comb
    begin
        if (in_window)
        begin
            cls_status = slot_valid_reg[wr_slot] ? srrr_pkg::STAT_DUPLICATE
                                                 : srrr_pkg::STAT_BUFFERED;
        end
        else if (seq_off < srrr_pkg::HALF_SEQ)
        begin
            cls_status = srrr_pkg::STAT_BEYOND;
        end
        else
        begin
            cls_status = srrr_pkg::STAT_STALE;
        end
    end

    always_comb
    begin
        state_next      = state_reg;
        expected_next   = expected_reg;
        head_next       = head_reg;
        slot_valid_next = slot_valid_reg;
        out_item_next   = out_item_reg;
        emit            = 1'b0;
        q_pop           = 1'b0;
        wr_en           = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (q_valid && can_emit)
                begin
                    emit = 1'b1;
                    if (in_order)
                    begin
                        out_item_next.kind    = srrr_pkg::KIND_DATA;
                        out_item_next.seq     = q_item.seq;
                        out_item_next.payload = q_item.payload;
                        out_item_next.status  = srrr_pkg::STAT_IN_ORDER;
                        out_item_next.last    = 1'b0;
                        expected_next = expected_reg + srrr_pkg::SEQ_W'(1);
                        head_next     = head_inc;
                        state_next    = ST_DRAIN;
                    end
                    else
                    begin
                        out_item_next.kind    = srrr_pkg::KIND_ACK;
                        out_item_next.seq     = q_item.seq;
                        out_item_next.payload = '0;
                        out_item_next.status  = cls_status;
                        out_item_next.last    = 1'b1;
                        q_pop = 1'b1;
                        if (cls_status == srrr_pkg::STAT_BUFFERED)
                        begin
                            wr_en = 1'b1;
                            slot_valid_next[wr_slot] = 1'b1;
                        end
                    end
                end
            end
            ST_DRAIN:
            begin
                if (can_emit)
                begin
                    emit = 1'b1;
                    if (drain_hit)
                    begin
                        out_item_next.kind    = srrr_pkg::KIND_DATA;
                        out_item_next.seq     = expected_reg;
                        out_item_next.payload = rd_data_reg;
                        out_item_next.status  = srrr_pkg::STAT_IN_ORDER;
                        out_item_next.last    = 1'b0;
                        slot_valid_next[head_reg] = 1'b0;
                        expected_next = expected_reg + srrr_pkg::SEQ_W'(1);
                        head_next     = head_inc;
                    end
                    else
                    begin
                        out_item_next.kind    = srrr_pkg::KIND_ACK;
                        out_item_next.seq     = q_item.seq;
                        out_item_next.payload = '0;
                        out_item_next.status  = srrr_pkg::STAT_IN_ORDER;
                        out_item_next.last    = 1'b1;
                        q_pop      = 1'b1;
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            expected_reg   <= '0;
            head_reg       <= '0;
            slot_valid_reg <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            expected_reg   <= expected_next;
            head_reg       <= head_next;
            slot_valid_reg <= slot_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // Read the slot that will be the head next cycle, so its payload is ready to drain.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            slot_mem[wr_slot] <= q_item.payload;
        end
        rd_data_reg  <= slot_mem[head_next];
        out_item_reg <= out_item_next;
    end

    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

    a_pop_needs_item: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> q_valid)
        else $error("engine popped an empty queue");

    a_store_free_slot: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |-> !slot_valid_reg[wr_slot])
        else $error("buffered packet overwrote an occupied slot");

    a_drain_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DRAIN && can_emit && drain_hit)
        |=> !slot_valid_reg[$past(head_reg)])
        else $error("drained slot still marked valid");

    a_expected_step: assert property (@(posedge clk) disable iff (!rst_n)
        (expected_reg != $past(expected_reg))
        |-> (expected_reg == $past(expected_reg) + srrr_pkg::SEQ_W'(1)))
        else $error("expected sequence moved by more than one");

endmodule

// ===== design/selective_repeat_reorder_receiver_unit.sv =====
// Selective-repeat receiver top level: window limit register, input queue
// and reorder engine. Depends on srrr_pkg, srrr_in_queue and srrr_engine.
`timescale 1ns / 1ps

// A packet that is stale, beyond the window, a duplicate or newly buffered
// yields one acknowledgement. An in-order packet followed by k stored
// packets yields its own delivery, one delivery per drained packet, then the
// acknowledgement. The drain sequencer reads one reorder slot per cycle
// through the store's single read port and pushes one result per cycle into
// the output register while the output is not stalled. A two-entry input
// queue keeps accepting requests while results are stalled, until it is full.
// The slot valid bits clear at reset, so no clearing pass is needed.

module selective_repeat_reorder_receiver_unit
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [srrr_pkg::LIMIT_W-1:0]  cfg_wdata,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [srrr_pkg::SEQ_W-1:0]    seq_number,
    input  logic [srrr_pkg::PAY_W-1:0]    payload_word,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic                          item_kind,
    output logic [srrr_pkg::SEQ_W-1:0]    out_seq,
    output logic [srrr_pkg::PAY_W-1:0]    out_payload,
    output logic [srrr_pkg::STAT_W-1:0]   ack_status,
    output logic                          last_of_run
);

    logic [srrr_pkg::LIMIT_W-1:0] window_limit_reg;
    srrr_pkg::pkt_t               in_item;
    srrr_pkg::pkt_t               q_item;
    logic                         q_valid;
    logic                         q_pop;
    srrr_pkg::out_item_t          res_item;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_limit_reg <= srrr_pkg::LIMIT_RESET;
        end
        else if (cfg_we)
        begin
            window_limit_reg <= cfg_wdata;
        end
    end

    assign in_item.seq     = seq_number;
    assign in_item.payload = payload_word;

    srrr_in_queue u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (in_valid),
        .push_ready (in_ready),
        .push_item  (in_item),
        .head_valid (q_valid),
        .head_item  (q_item),
        .pop        (q_pop)
    );

    srrr_engine u_engine
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_valid      (q_valid),
        .q_item       (q_item),
        .q_pop        (q_pop),
        .window_limit (window_limit_reg),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .out_item     (res_item)
    );

    assign item_kind   = res_item.kind;
    assign out_seq     = res_item.seq;
    assign out_payload = res_item.payload;
    assign ack_status  = res_item.status;
    assign last_of_run = res_item.last;

endmodule
